>>> hw/rtl/hde_pkg.sv
// Package for the heightmap drop erosion block: sizes, field widths,
// register indexes, action codes and sequencer states. No dependencies.
package hde_pkg;
  localparam int MaxCols    = 128;
  localparam int MaxRows    = 64;
  localparam int HeightBits = 16;
  localparam int ColBits    = $clog2(MaxCols);
  localparam int RowBits    = $clog2(MaxRows);
  localparam int AddrBits   = ColBits + RowBits;
  localparam int CellCount  = MaxCols * MaxRows;
  localparam logic [12:0] StepMax = 13'h1FFF;

  localparam logic [1:0] CfgGain = 2'd0;
  localparam logic [1:0] CfgCols = 2'd1;
  localparam logic [1:0] CfgRows = 2'd2;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActDrop  = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ_WAIT, ST_READ_DONE, ST_DIV, ST_CEN_REQ, ST_CEN_WAIT,
    ST_NB_REQ, ST_NB_WAIT, ST_NB_CMP, ST_MUL, ST_WRBACK, ST_OUT
  } state_t;

  // Neighbour offsets in scan order, stored as offset + 1.
  function automatic logic [1:0] nb_dc(input logic [2:0] i);
    logic [1:0] t [8];
    t = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
    return t[i];
  endfunction
  function automatic logic [1:0] nb_dr(input logic [2:0] i);
    logic [1:0] t [8];
    t = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    return t[i];
  endfunction
endpackage

>>> hw/rtl/hde_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module hde_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/heightmap_drop_erosion_top.sv
// Top level of the heightmap drop erosion block: handshakes, sequencer,
// shared compare unit and multiplier. Depends on hde_pkg and hde_ram.
// A drop runs the start modulo, then for each cell visited reads the centre and
// each in-grid neighbour on the one RAM port and writes the eroded centre back
// once per move.
// One transaction at a time; in_tready is low while an item is at work.
// rst_n is synchronous and active low; it restores the register defaults and
// empties the control state. Height store contents are undefined until written.
module heightmap_drop_erosion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], col[8:2], row[14:9], cell_height[30:15], zero pad [31]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_height[15:0], end_col[22:16], end_row[28:23], step_count[41:29],
  // sediment[73:42], zero pad [79:74]
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int CB = hde_pkg::ColBits;
  localparam int RB = hde_pkg::RowBits;
  localparam int HB = hde_pkg::HeightBits;

  // Configuration registers; writes are taken at any time.
  logic [15:0] gain_r;
  logic [7:0]  cols_cfg_r;
  logic [6:0]  rows_cfg_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd49152;
      cols_cfg_r <= 8'd128;
      rows_cfg_r <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hde_pkg::CfgGain: gain_r <= cfg_data;
        hde_pkg::CfgCols: cols_cfg_r <= cfg_data[7:0];
        hde_pkg::CfgRows: rows_cfg_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamped grid size, one bit wider than a coordinate.
  logic [CB:0] cols;
  logic [RB:0] rows;
  always_comb begin
    if (cols_cfg_r == 8'd0) cols = (CB+1)'(1);
    else if (cols_cfg_r > 8'(hde_pkg::MaxCols)) cols = (CB+1)'(hde_pkg::MaxCols);
    else cols = cols_cfg_r[CB:0];
    if (rows_cfg_r == 7'd0) rows = (RB+1)'(1);
    else if (rows_cfg_r > 7'(hde_pkg::MaxRows)) rows = (RB+1)'(hde_pkg::MaxRows);
    else rows = rows_cfg_r[RB:0];
  end

  hde_pkg::state_t state_r, state_nxt;

  logic [CB-1:0] cc_r, cc_nxt, nc_r, nc_nxt;
  logic [RB-1:0] cr_r, cr_nxt, nr_r, nr_nxt;
  logic [CB:0]   mc_r, mc_nxt;  // column remainder during the modulo
  logic [RB:0]   mr_r, mr_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [HB-1:0] v_r, v_nxt, best_r, best_nxt;
  logic [HB-1:0] ero_r, ero_nxt;
  logic [12:0]   steps_r, steps_nxt;
  logic [31:0]   sed_r, sed_nxt;
  logic [79:0]   out_r, out_nxt;
  logic          outv_r, outv_nxt;

  logic            ram_we;
  logic [CB+RB-1:0] ram_addr;
  logic [HB-1:0]   ram_wdata, ram_rdata;

  hde_ram #(.Width(HB), .Depth(hde_pkg::CellCount)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [1:0]    in_act;
  logic [CB-1:0] in_col;
  logic [RB-1:0] in_row;
  assign in_act = in_tdata[1:0];
  assign in_col = in_tdata[8:2];
  assign in_row = in_tdata[14:9];

  // Neighbour coordinates with two extra bits to spot out-of-grid positions.
  logic [CB+1:0] xc;
  logic [RB+1:0] yr;
  logic          nb_in;
  assign xc = {2'b00, cc_r} + (CB+2)'(hde_pkg::nb_dc(idx_r)) - (CB+2)'(1);
  assign yr = {2'b00, cr_r} + (RB+2)'(hde_pkg::nb_dr(idx_r)) - (RB+2)'(1);
  assign nb_in = !xc[CB+1] && (xc < (CB+2)'(cols)) && !yr[RB+1] && (yr < (RB+2)'(rows));

  logic [31:0] prod;
  logic [32:0] sed_sum;
  assign prod = gain_r * best_r;
  assign sed_sum = {1'b0, sed_r} + 33'(best_r);

  assign in_tready  = (state_r == hde_pkg::ST_IDLE) && !outv_r;
  assign out_tvalid = outv_r;
  assign out_tdata  = out_r;

  always_comb begin
    state_nxt = state_r;
    cc_nxt = cc_r; cr_nxt = cr_r; nc_nxt = nc_r; nr_nxt = nr_r;
    mc_nxt = mc_r; mr_nxt = mr_r; idx_nxt = idx_r;
    v_nxt = v_r; best_nxt = best_r; ero_nxt = ero_r;
    steps_nxt = steps_r; sed_nxt = sed_r;
    out_nxt = out_r; outv_nxt = outv_r;
    ram_we = 1'b0;
    ram_addr = {cr_r, cc_r};
    ram_wdata = v_r - ero_r;
    if (outv_r && out_tready) outv_nxt = 1'b0;
    unique case (state_r)
      hde_pkg::ST_IDLE: begin
        ram_addr = {in_row, in_col};
        ram_wdata = in_tdata[30:15];
        if (in_tvalid && in_tready) begin
          out_nxt = '0;
          unique case (in_act)
            hde_pkg::ActWrite: begin
              ram_we = 1'b1;
              state_nxt = hde_pkg::ST_OUT;
            end
            hde_pkg::ActDrop: begin
              mc_nxt = {1'b0, in_col};
              mr_nxt = {1'b0, in_row};
              steps_nxt = '0;
              sed_nxt = '0;
              idx_nxt = '0;
              state_nxt = hde_pkg::ST_DIV;
            end
            hde_pkg::ActRead: begin
              // Keep the read address, since the input may change after
              // acceptance and the RAM port is re-addressed every cycle.
              cc_nxt = in_col;
              cr_nxt = in_row;
              state_nxt = hde_pkg::ST_READ_WAIT;
            end
            default: state_nxt = hde_pkg::ST_OUT;
          endcase
        end
      end
      hde_pkg::ST_READ_WAIT: state_nxt = hde_pkg::ST_READ_DONE;
      hde_pkg::ST_READ_DONE: begin
        out_nxt[15:0] = ram_rdata;
        state_nxt = hde_pkg::ST_OUT;
      end
      // Start modulo by repeated subtraction of the grid size, both coordinates
      // in parallel; the start is below 2^7, so at most 127 subtractions.
      hde_pkg::ST_DIV: begin
        if (mc_r >= cols) mc_nxt = mc_r - cols;
        if (mr_r >= rows) mr_nxt = mr_r - rows;
        if (mc_r < cols && mr_r < rows) begin
          cc_nxt = mc_r[CB-1:0];
          cr_nxt = mr_r[RB-1:0];
          state_nxt = hde_pkg::ST_CEN_REQ;
        end
      end
      hde_pkg::ST_CEN_REQ: state_nxt = hde_pkg::ST_CEN_WAIT;
      hde_pkg::ST_CEN_WAIT: begin
        v_nxt = ram_rdata;
        best_nxt = '0;
        idx_nxt = '0;
        state_nxt = hde_pkg::ST_NB_REQ;
      end
      hde_pkg::ST_NB_REQ: begin
        ram_addr = {yr[RB-1:0], xc[CB-1:0]};
        state_nxt = nb_in ? hde_pkg::ST_NB_WAIT : hde_pkg::ST_NB_CMP;
      end
      // The neighbour address is held so the read data stays on the neighbour.
      hde_pkg::ST_NB_WAIT: begin
        ram_addr = {yr[RB-1:0], xc[CB-1:0]};
        state_nxt = hde_pkg::ST_NB_CMP;
      end
      hde_pkg::ST_NB_CMP: begin
        if (nb_in && ram_rdata < v_r && (v_r - ram_rdata) > best_r) begin
          best_nxt = v_r - ram_rdata;
          nc_nxt = xc[CB-1:0];
          nr_nxt = yr[RB-1:0];
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) state_nxt = hde_pkg::ST_MUL;
        else state_nxt = hde_pkg::ST_NB_REQ;
      end
      hde_pkg::ST_MUL: begin
        if (best_r == '0) begin
          out_nxt = '0;
          out_nxt[22:16] = cc_r;
          out_nxt[28:23] = cr_r;
          out_nxt[41:29] = steps_r;
          out_nxt[73:42] = sed_r;
          state_nxt = hde_pkg::ST_OUT;
        end else begin
          ero_nxt = prod[31:16];
          sed_nxt = sed_sum[32] ? 32'hFFFF_FFFF : sed_sum[31:0];
          if (steps_r != hde_pkg::StepMax) steps_nxt = steps_r + 13'd1;
          state_nxt = hde_pkg::ST_WRBACK;
        end
      end
      hde_pkg::ST_WRBACK: begin
        ram_we = 1'b1;
        cc_nxt = nc_r;
        cr_nxt = nr_r;
        state_nxt = hde_pkg::ST_CEN_REQ;
      end
      hde_pkg::ST_OUT: begin
        outv_nxt = 1'b1;
        state_nxt = hde_pkg::ST_IDLE;
      end
      default: state_nxt = hde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hde_pkg::ST_IDLE;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r <= outv_nxt;
    end
    cc_r <= cc_nxt; cr_r <= cr_nxt; nc_r <= nc_nxt; nr_r <= nr_nxt;
    mc_r <= mc_nxt; mr_r <= mr_nxt; idx_r <= idx_nxt;
    v_r <= v_nxt; best_r <= best_nxt; ero_r <= ero_nxt;
    steps_r <= steps_nxt; sed_r <= sed_nxt;
    out_r <= out_nxt;
  end

  // A result is never overwritten while it waits.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // No item is taken while a result waits.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted with result pending");
  // Erosion always leaves the cell strictly above its lowest neighbour.
  a_ero_less: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hde_pkg::ST_WRBACK |-> ero_r < best_r)
    else $error("erosion not below slope");
endmodule

>>> sim/tb_heightmap_drop_erosion_top.sv
// Self-checking testbench for heightmap_drop_erosion_top: loads part of the grid,
// runs directed and random write/drop/read items and checks every result.
// Depends on hde_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_heightmap_drop_erosion_top;

  // Action code that the block must treat as a no-op with an all-zero result.
  localparam logic [1:0] ActNone = 2'd3;
  localparam int ClkHalf = 6;

  // Result fields, lowest field last so the struct maps onto out_tdata[73:0].
  typedef struct packed {
    logic [31:0] sediment;
    logic [12:0] step_count;
    logic [5:0]  end_row;
    logic [6:0]  end_col;
    logic [15:0] read_height;
  } erosion_result_t;

  // One row of the directed table. When has_fixed is set the expected
  // result is typed in; otherwise the predictor supplies it.
  typedef struct {
    logic [1:0]      act;
    logic [6:0]      col;
    logic [5:0]      row;
    logic [15:0]     hgt;
    bit              has_fixed;
    erosion_result_t fixed;
  } directed_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #(ClkHalf) clk = ~clk;

  heightmap_drop_erosion_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the block's state, kept by the predictor.
  logic [15:0] shadow_height [hde_pkg::CellCount];
  logic [15:0] shadow_gain;
  logic [7:0]  shadow_cols;
  logic [6:0]  shadow_rows;

  erosion_result_t pending_results [$];
  int error_count;
  int checked_count;
  int drop_count;
  int moves_seen;

  // Idle percentages for the two sides and the receiver's long hold-off.
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;

  // Cells that are loaded: row 0, column 0 and the 16 x 4 corner block.
  // Every grid used below stays inside these cells.
  function automatic bit is_loaded(int c, int r);
    return (r == 0) || (c == 0) || (r < 4 && c < 16);
  endfunction

  function automatic void pick_loaded_cell(output logic [6:0] col, output logic [5:0] row);
    int zone;
    zone = $urandom_range(2);
    case (zone)
      0: begin
        col = 7'($urandom);
        row = 6'd0;
      end
      1: begin
        col = 7'd0;
        row = 6'($urandom);
      end
      default: begin
        col = 7'($urandom_range(15));
        row = 6'($urandom_range(3));
      end
    endcase
  endfunction

  // Walks one drop over the shadow grid, eroding as it goes.
  function automatic erosion_result_t run_shadow_drop(logic [6:0] c0, logic [5:0] r0);
    erosion_result_t res;
    int cols;
    int rows;
    int cc;
    int cr;
    int nc;
    int nr;
    int xc;
    int yr;
    int steps;
    longint unsigned sed;
    longint unsigned ero;
    logic [15:0] v;
    logic [15:0] hn;
    logic [16:0] best;
    int dc [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int dr [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    res = '0;
    cols = (shadow_cols == 0) ? 1 :
           (shadow_cols > hde_pkg::MaxCols) ? hde_pkg::MaxCols : shadow_cols;
    rows = (shadow_rows == 0) ? 1 :
           (shadow_rows > hde_pkg::MaxRows) ? hde_pkg::MaxRows : shadow_rows;
    cc = c0 % cols;
    cr = r0 % rows;
    steps = 0;
    sed = 0;
    forever begin
      v = shadow_height[cr * hde_pkg::MaxCols + cc];
      best = 0;
      nc = 0;
      nr = 0;
      for (int i = 0; i < 8; i++) begin
        xc = cc + dc[i];
        yr = cr + dr[i];
        if (xc >= 0 && xc < cols && yr >= 0 && yr < rows) begin
          hn = shadow_height[yr * hde_pkg::MaxCols + xc];
          // Strictly greater keeps the first steepest neighbour on a tie.
          if (hn < v && 17'(v - hn) > best) begin
            best = 17'(v - hn);
            nc = xc;
            nr = yr;
          end
        end
      end
      if (best == 0) break;
      ero = (longint'(shadow_gain) * longint'(best)) >> 16;
      shadow_height[cr * hde_pkg::MaxCols + cc] = v - 16'(ero);
      sed += best;
      if (sed > 64'hFFFF_FFFF) sed = 64'hFFFF_FFFF;
      if (steps < hde_pkg::StepMax) steps++;
      cc = nc;
      cr = nr;
    end
    res.end_col = 7'(cc);
    res.end_row = 6'(cr);
    res.step_count = 13'(steps);
    res.sediment = 32'(sed);
    return res;
  endfunction

  // Applies one accepted item to the shadow state and returns its result.
  function automatic erosion_result_t predict_result(logic [1:0] act, logic [6:0] col,
                                                     logic [5:0] row, logic [15:0] hgt);
    erosion_result_t res;
    res = '0;
    case (act)
      hde_pkg::ActWrite: shadow_height[row * hde_pkg::MaxCols + col] = hgt;
      hde_pkg::ActDrop: begin
        res = run_shadow_drop(col, row);
        drop_count++;
        moves_seen += res.step_count;
      end
      hde_pkg::ActRead: res.read_height = shadow_height[row * hde_pkg::MaxCols + col];
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    error_count++;
  endtask

  task automatic queue_expected(erosion_result_t res);
    pending_results = {pending_results, res};
  endtask

  // Offers one item, with random idle cycles ahead of it, until the block
  // takes it; the expectation is queued at the accepting edge. tvalid is
  // left high so back-to-back items need no second assignment in a step.
  task automatic send_item(logic [1:0] act, logic [6:0] col, logic [5:0] row,
                           logic [15:0] hgt, bit has_fixed, erosion_result_t fixed);
    erosion_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, hgt, row, col, act};
    do @(posedge clk); while (!in_tready);
    res = predict_result(act, col, row, hgt);
    queue_expected(has_fixed ? fixed : res);
  endtask

  task automatic send_random_item();
    int pick;
    logic [6:0] rd_col;
    logic [5:0] rd_row;
    pick = $urandom_range(99);
    if (pick < 22) begin
      send_item(hde_pkg::ActWrite, 7'($urandom), 6'($urandom), 16'($urandom), 1'b0, '0);
    end else if (pick < 77) begin
      send_item(hde_pkg::ActDrop, 7'($urandom), 6'($urandom), 16'($urandom), 1'b0, '0);
    end else if (pick < 94) begin
      pick_loaded_cell(rd_col, rd_row);
      send_item(hde_pkg::ActRead, rd_col, rd_row, 16'($urandom), 1'b0, '0);
    end else begin
      send_item(ActNone, 7'($urandom), 6'($urandom), 16'($urandom), 1'b0, '0);
    end
  endtask

  // Drops tvalid and waits until every queued result has come back, plus a
  // short margin so the block is idle before a register write.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hde_pkg::CfgGain: shadow_gain = value;
      hde_pkg::CfgCols: shadow_cols = value[7:0];
      hde_pkg::CfgRows: shadow_rows = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [15:0] gain, logic [7:0] cols, logic [6:0] rows);
    drain_results();
    write_register(hde_pkg::CfgGain, gain);
    write_register(hde_pkg::CfgCols, {8'd0, cols});
    write_register(hde_pkg::CfgRows, {9'd0, rows});
    cfg_valid <= 1'b0;
  endtask

  // Receiver: picks tready at random (or holds it low during a hold-off) and
  // checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    erosion_result_t got;
    erosion_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = erosion_result_t'(out_tdata[73:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 0, out_tdata[63:0]);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.read_height !== want.read_height)
          report_mismatch("read_height", want.read_height, got.read_height);
        if (got.end_col !== want.end_col)
          report_mismatch("end_col", want.end_col, got.end_col);
        if (got.end_row !== want.end_row)
          report_mismatch("end_row", want.end_row, got.end_row);
        if (got.step_count !== want.step_count)
          report_mismatch("step_count", want.step_count, got.step_count);
        if (got.sediment !== want.sediment)
          report_mismatch("sediment", want.sediment, got.sediment);
        if (out_tdata[79:74] !== 6'd0)
          report_mismatch("pad bits", 0, out_tdata[79:74]);
      end
    end
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Directed items, run on a 16 x 4 grid right after loading.
  // Corner (15,3) is written to zero, so a drop there cannot move.
  directed_item_t directed_items [14];

  initial begin
    erosion_result_t zero_res;
    erosion_result_t fixed_res;
    zero_res = '0;
    directed_items[0]  = '{hde_pkg::ActWrite, 7'd0,  6'd0, 16'hFFFF, 1'b1, zero_res};
    fixed_res = '0;
    fixed_res.read_height = 16'hFFFF;
    directed_items[1]  = '{hde_pkg::ActRead,  7'd0,  6'd0, 16'h0000, 1'b1, fixed_res};
    directed_items[2]  = '{hde_pkg::ActWrite, 7'd15, 6'd3, 16'h0000, 1'b1, zero_res};
    directed_items[3]  = '{hde_pkg::ActRead,  7'd15, 6'd3, 16'hFFFF, 1'b1, zero_res};
    fixed_res = '0;
    fixed_res.end_col = 7'd15;
    fixed_res.end_row = 6'd3;
    directed_items[4]  = '{hde_pkg::ActDrop,  7'd15, 6'd3, 16'h0000, 1'b1, fixed_res};
    directed_items[5]  = '{ActNone,           7'd15, 6'd3, 16'hFFFF, 1'b1, zero_res};
    directed_items[6]  = '{hde_pkg::ActDrop,  7'd0,  6'd0, 16'hFFFF, 1'b0, zero_res};
    directed_items[7]  = '{hde_pkg::ActDrop,  7'd15, 6'd0, 16'h5555, 1'b0, zero_res};
    directed_items[8]  = '{hde_pkg::ActDrop,  7'd0,  6'd3, 16'hAAAA, 1'b0, zero_res};
    directed_items[9]  = '{hde_pkg::ActWrite, 7'd8,  6'd2, 16'h8000, 1'b1, zero_res};
    directed_items[10] = '{hde_pkg::ActDrop,  7'd8,  6'd2, 16'h0000, 1'b0, zero_res};
    directed_items[11] = '{hde_pkg::ActRead,  7'd8,  6'd2, 16'h0000, 1'b0, zero_res};
    directed_items[12] = '{hde_pkg::ActDrop,  7'd85, 6'd42, 16'h0001, 1'b0, zero_res};
    directed_items[13] = '{hde_pkg::ActRead,  7'd10, 6'd1, 16'hFFFF, 1'b0, zero_res};
  end

  // Main sequence: reset, load the used cells, directed table, then six
  // random phases under different register settings and idle patterns.
  initial begin
    logic [15:0] phase_gain [6];
    logic [7:0]  phase_cols [6];
    logic [6:0]  phase_rows [6];
    error_count = 0;
    checked_count = 0;
    drop_count = 0;
    moves_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 0;
    shadow_gain = 16'd49152;
    shadow_cols = 8'd128;
    shadow_rows = 7'd64;

    // Settings per phase: the directed grid, an oversize column count that
    // clamps to the maximum, zero sizes that clamp to one cell, a random grid,
    // a single 16-column row and an oversize row count on a single column.
    phase_gain = '{16'd49152, 16'd0, 16'hFFFF, 16'($urandom), 16'hFFFF, 16'($urandom)};
    phase_cols = '{8'd16, 8'd255, 8'd0, 8'($urandom_range(1, 16)), 8'd16, 8'd1};
    phase_rows = '{7'd4, 7'd1, 7'd0, 7'($urandom_range(1, 4)), 7'd1, 7'd127};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 60;

    // Every cell that a drop or read can reach is written first. The terrain
    // slopes toward the origin with noise, so drops walk a fair distance
    // but still meet local pits.
    for (int r = 0; r < hde_pkg::MaxRows; r++)
      for (int c = 0; c < hde_pkg::MaxCols; c++)
        if (is_loaded(c, r))
          send_item(hde_pkg::ActWrite, 7'(c), 6'(r),
                    16'(c * 200 + r * 300 + $urandom_range(0, 1500)), 1'b0, '0);

    set_grid(phase_gain[0], phase_cols[0], phase_rows[0]);
    foreach (directed_items[i])
      send_item(directed_items[i].act, directed_items[i].col, directed_items[i].row,
                directed_items[i].hgt, directed_items[i].has_fixed, directed_items[i].fixed);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) set_grid(phase_gain[p], phase_cols[p], phase_rows[p]);
      send_idle_pct = (p < 2) ? 28 : (p < 4) ? 60 : 0;
      recv_idle_pct = (p < 2) ? 60 : (p < 4) ? 28 : 0;
      for (int n = 0; n < 36; n++) begin
        // A long receiver hold-off while the sender keeps offering items,
        // so the block backs up and stalls its input.
        if (p == 3 && n == 6) recv_hold_cycles = 600;
        // A sender pause until every result is back, mid-phase.
        if (n == 20) drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    $display("Checked %0d result transactions, %0d of them drops with %0d moves in total,",
             checked_count, drop_count, moves_seen);
    $display("across six register settings including clamped and one-cell grids.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200ms;
    $display("Timeout with %0d results still outstanding.", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
